// ===== hw/rtl/rational_arithmetic_unit_defines.svh =====
// assertion macros for the rational arithmetic unit
`ifndef RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
`define RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH

// implication checked on every clock edge outside reset
`define RAU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// implication whose consequent is checked in the next cycle
`define RAU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/rau_pkg.sv =====
// ----------------------------------------------------------------------------
// rau_pkg
// shared types and constants of the rational arithmetic unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package rau_pkg;
  localparam int unsigned WordBitsDefault = 32;
  localparam int unsigned NumBits = 32;
  localparam int unsigned DenBits = 31;
  localparam int unsigned ProdBits = 64;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_CMP = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DIV_ZERO = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_e;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [31:0] a_num;
    logic [30:0] a_den;
    logic [31:0] b_num;
    logic [30:0] b_den;
  } req_t;

  typedef struct packed {
    logic [31:0] res_num;
    logic [30:0] res_den;
    logic        is_less;
    logic        is_equal;
    logic        is_greater;
    logic [1:0]  status;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture request, take magnitudes
    logic mul_start; // start a product
    logic mul_step;  // one product bit
    logic mul_sel;   // which product (0 first, 1 second)
    logic form;      // combine products into mag, den
    logic gcd_init;
    logic mod_step;  // one restoring-remainder bit
    logic gcd_swap;  // x <- y, y <- remainder
    logic div_start;
    logic div_step;
    logic div_sel;   // 0 divide mag, 1 divide den
    logic finish;    // build result
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic y_zero;
    logic mag_zero;
    logic early;     // result settled without reduction
  } sts_t;
endpackage

// ===== hw/rtl/rau_if.sv =====
// ----------------------------------------------------------------------------
// rau_if
// valid/ready channel carrying one payload
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
interface rau_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/rau_datapath.sv =====
// ----------------------------------------------------------------------------
// rau_datapath
// shift-add multiplier, restoring remainder and divider, result formatting
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module rau_datapath import rau_pkg::*; #(
  parameter int unsigned WordBits = WordBitsDefault
) (
  input  logic clk_i,
  input  req_t req_i,
  input  cmd_t cmd_i,
  output sts_t sts_o,
  output rsp_t rsp_o
);
  localparam logic [ProdBits-1:0] Half = ProdBits'(1) << (WordBits - 1);

  req_t              req_q;
  logic [NumBits-1:0] am_q, bm_q;
  logic              aneg_q, bneg_q;
  logic [ProdBits-1:0] p_q, q_q, mc_q, mp_q;
  logic [NumBits-1:0] mr_q;
  logic [ProdBits-1:0] mag_q, den_q, x_q, y_q, r_q, w_q, quo_q;
  logic              neg_q;
  logic [5:0]        bit_q;
  logic              early_q;
  rsp_t              rsp_q, rsp_d;

  logic signed [32:0] an_s, bn_s;
  assign an_s = {req_q.a_num[31], req_q.a_num};
  assign bn_s = {req_q.b_num[31], req_q.b_num};

  logic [ProdBits:0] rsh;
  assign rsh = {r_q, w_q[ProdBits-1]};

  logic [ProdBits-1:0] dvs;
  assign dvs = cmd_i.div_sel ? den_q : mag_q;
  logic [ProdBits:0] qsh;
  assign qsh = {r_q, w_q[ProdBits-1]};

  logic qneg;
  assign qneg = (req_q.req_type == OP_SUB) ? !bneg_q : bneg_q;

  // result of the current request
  always_comb begin
    rsp_d = '{res_num: '0, res_den: 31'd1, is_less: 1'b0, is_equal: 1'b0,
              is_greater: 1'b0, status: ST_OK};
    if (req_q.a_den == '0 || req_q.b_den == '0) begin
      rsp_d.status = ST_DIV_ZERO;
    end else if (req_q.req_type == OP_CMP) begin
      rsp_d.is_less    = $signed(p_q) < $signed(q_q);
      rsp_d.is_equal   = p_q == q_q;
      rsp_d.is_greater = $signed(p_q) > $signed(q_q);
    end else if (req_q.req_type == OP_DIV && bm_q == '0) begin
      rsp_d.status = ST_DIV_ZERO;
    end else if (req_q.req_type > OP_CMP) begin
      rsp_d.status = ST_OK;
    end else if (mag_q == '0) begin
      rsp_d.status = ST_OK;
    end else if (den_q > Half - 1 || mag_q > (neg_q ? Half : Half - 1)) begin
      rsp_d.status = ST_OVERFLOW;
    end else begin
      rsp_d.res_num = neg_q ? 32'(64'd0 - mag_q) : mag_q[31:0];
      rsp_d.res_den = den_q[30:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q  <= req_i;
      aneg_q <= req_i.a_num[31];
      bneg_q <= req_i.b_num[31];
      am_q   <= req_i.a_num[31] ? (32'd0 - req_i.a_num) : req_i.a_num;
      bm_q   <= req_i.b_num[31] ? (32'd0 - req_i.b_num) : req_i.b_num;
    end
    // shift-add product of multiplicand and a 32-bit multiplier
    if (cmd_i.mul_start) begin
      mp_q <= '0;
      case (req_q.req_type)
        OP_ADD, OP_SUB: begin
          mc_q <= cmd_i.mul_sel ? {32'd0, bm_q} : {32'd0, am_q};
          mr_q <= cmd_i.mul_sel ? {1'b0, req_q.a_den} : {1'b0, req_q.b_den};
        end
        OP_MUL: begin
          mc_q <= cmd_i.mul_sel ? {33'd0, req_q.a_den} : {32'd0, am_q};
          mr_q <= cmd_i.mul_sel ? {1'b0, req_q.b_den} : bm_q;
        end
        OP_DIV: begin
          mc_q <= cmd_i.mul_sel ? {33'd0, req_q.a_den} : {32'd0, am_q};
          mr_q <= cmd_i.mul_sel ? bm_q : {1'b0, req_q.b_den};
        end
        OP_CMP: begin
          // sign-extended numerator times positive denominator
          mc_q <= cmd_i.mul_sel ? {{32{bn_s[32]}}, req_q.b_num}
                                : {{32{an_s[32]}}, req_q.a_num};
          mr_q <= cmd_i.mul_sel ? {1'b0, req_q.a_den} : {1'b0, req_q.b_den};
        end
        default: begin
          mc_q <= '0;
          mr_q <= '0;
        end
      endcase
    end else if (cmd_i.mul_step) begin
      if (mr_q[0]) mp_q <= mp_q + mc_q;
      mc_q <= mc_q << 1;
      mr_q <= mr_q >> 1;
    end
    if (cmd_i.mul_step && mr_q == '0) begin
      if (cmd_i.mul_sel) q_q <= mp_q;
      else p_q <= mp_q;
    end
    if (cmd_i.form) begin
      early_q <= 1'b0;
      case (req_q.req_type)
        OP_ADD, OP_SUB: begin
          // p = am*bd, q = bm*ad; den is the product of the denominators
          if (aneg_q == qneg) begin
            mag_q <= p_q + q_q; neg_q <= aneg_q;
          end else if (p_q >= q_q) begin
            mag_q <= p_q - q_q; neg_q <= aneg_q;
          end else begin
            mag_q <= q_q - p_q; neg_q <= qneg;
          end
          den_q <= 64'(req_q.a_den) * 64'(req_q.b_den);
        end
        default: begin
          // multiply: am*bm over ad*bd, divide: am*bd over ad*bm
          mag_q <= p_q; neg_q <= aneg_q ^ bneg_q;
          den_q <= q_q;
        end
      endcase
    end
    if (cmd_i.gcd_init) begin
      x_q <= mag_q; y_q <= den_q; r_q <= '0; w_q <= mag_q; bit_q <= '0;
    end else if (cmd_i.mod_step) begin
      if (rsh >= {1'b0, y_q}) r_q <= ProdBits'(rsh - {1'b0, y_q});
      else r_q <= rsh[ProdBits-1:0];
      w_q <= w_q << 1;
      bit_q <= bit_q + 6'd1;
    end else if (cmd_i.gcd_swap) begin
      x_q <= y_q; y_q <= r_q; w_q <= y_q; r_q <= '0; bit_q <= '0;
    end else if (cmd_i.div_start) begin
      r_q <= '0; w_q <= dvs; quo_q <= '0; bit_q <= '0;
    end else if (cmd_i.div_step) begin
      if (qsh >= {1'b0, x_q}) begin
        r_q <= ProdBits'(qsh - {1'b0, x_q}); quo_q <= {quo_q[ProdBits-2:0], 1'b1};
      end else begin
        r_q <= qsh[ProdBits-1:0]; quo_q <= {quo_q[ProdBits-2:0], 1'b0};
      end
      w_q <= w_q << 1;
      bit_q <= bit_q + 6'd1;
    end
    if (cmd_i.div_step && bit_q == 6'd63) begin
      if (cmd_i.div_sel) den_q <= {quo_q[ProdBits-2:0], qsh >= {1'b0, x_q}};
      else mag_q <= {quo_q[ProdBits-2:0], qsh >= {1'b0, x_q}};
    end
    if (cmd_i.finish) begin
      rsp_q <= rsp_d;
    end
  end

  assign sts_o.y_zero   = (y_q == '0);
  assign sts_o.mag_zero = (mag_q == '0);
  assign sts_o.early    = early_q || req_q.a_den == '0 || req_q.b_den == '0 ||
                          req_q.req_type > OP_DIV ||
                          (req_q.req_type == OP_DIV && bm_q == '0);
  assign rsp_o = rsp_q;
endmodule

// ===== hw/rtl/rau_ctrl.sv =====
// ----------------------------------------------------------------------------
// rau_ctrl
// sequencer for products, gcd loop, exact divisions and result handoff
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module rau_ctrl import rau_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);
  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_MUL0  = 10'b0000000010,
    S_MUL1  = 10'b0000000100,
    S_FORM  = 10'b0000001000,
    S_GINIT = 10'b0000010000,
    S_MOD   = 10'b0000100000,
    S_SWAP  = 10'b0001000000,
    S_DIV   = 10'b0010000000,
    S_FIN   = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_e;

  state_e state_q, state_d;
  logic [6:0] cnt_q, cnt_d;
  logic sel_q, sel_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    sel_d   = sel_q;
    cmd_o   = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1; state_d = S_MUL0; cnt_d = '0;
        end
      end
      S_MUL0, S_MUL1: begin
        cmd_o.mul_sel = (state_q == S_MUL1);
        if (cnt_q == '0) cmd_o.mul_start = 1'b1;
        else cmd_o.mul_step = 1'b1;
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'd33) begin
          cnt_d = '0;
          state_d = (state_q == S_MUL0) ? S_MUL1 : S_FORM;
        end
      end
      S_FORM: begin
        cmd_o.form = 1'b1; state_d = S_GINIT;
      end
      S_GINIT: begin
        if (sts_i.early || sts_i.mag_zero) state_d = S_FIN;
        else begin
          cmd_o.gcd_init = 1'b1; cnt_d = '0; state_d = S_MOD;
        end
      end
      S_MOD: begin
        if (sts_i.y_zero) begin
          state_d = S_DIV; cnt_d = '0; sel_d = 1'b0;
        end else begin
          cmd_o.mod_step = 1'b1; cnt_d = cnt_q + 7'd1;
          if (cnt_q == 7'd63) state_d = S_SWAP;
        end
      end
      S_SWAP: begin
        cmd_o.gcd_swap = 1'b1; cnt_d = '0; state_d = S_MOD;
      end
      S_DIV: begin
        cmd_o.div_sel = sel_q;
        if (cnt_q == '0) cmd_o.div_start = 1'b1;
        else cmd_o.div_step = 1'b1;
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'd64) begin
          cnt_d = '0; sel_d = 1'b1;
          if (sel_q) state_d = S_FIN;
        end
      end
      S_FIN: begin
        cmd_o.finish = 1'b1; state_d = S_OUT;
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; cnt_q <= '0; sel_q <= 1'b0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; sel_q <= sel_d;
    end
  end
endmodule

// ===== hw/rtl/rational_arithmetic_unit.sv =====
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// exact rational add, subtract, multiply, divide and compare with gcd reduction
// ----------------------------------------------------------------------------
// one request at a time: two shift-add products of a 32-bit multiplier,
// then the Euclidean gcd on a shared 64-step restoring remainder unit,
// then two 64-step exact divisions. compare, divide by zero and zero
// results skip the reduction and the divisions. the result register
// holds until taken
`timescale 1ns / 1ps
module rational_arithmetic_unit import rau_pkg::*; #(
  parameter int unsigned WordBits = WordBitsDefault
) (
  input logic   clk_i,
  input logic   rst_ni,
  rau_if.sink   req_i,
  rau_if.source rsp_o
);
  cmd_t cmd;
  sts_t sts;
  rsp_t rsp;

  // sequencer
  rau_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (req_i.valid), .in_ready_o (req_i.ready),
    .out_valid_o(rsp_o.valid), .out_ready_i(rsp_o.ready),
    .sts_i(sts), .cmd_o(cmd)
  );

  // arithmetic
  rau_datapath #(.WordBits(WordBits)) u_dp (
    .clk_i, .req_i(req_i.data), .cmd_i(cmd), .sts_o(sts), .rsp_o(rsp)
  );

  assign rsp_o.data = rsp;
endmodule

// ===== hw/rtl/rau_checker.sv =====
// ----------------------------------------------------------------------------
// rau_checker
// port-level checks of the rational arithmetic unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "rational_arithmetic_unit_defines.svh"
module rau_checker import rau_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input rsp_t out_data
);
  `RAU_ASSERT_IMP(a_one_at_a_time, clk_i, rst_ni, out_valid, !in_ready)
  `RAU_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid && !out_ready, out_valid)
  `RAU_ASSERT_IMP(a_den_pos, clk_i, rst_ni, out_valid, out_data.res_den != '0)
  `RAU_ASSERT_IMP(a_flags, clk_i, rst_ni, out_valid,
    $countones({out_data.is_less, out_data.is_equal, out_data.is_greater}) <= 1)
endmodule

bind rational_arithmetic_unit rau_checker u_chk (
  .clk_i, .rst_ni,
  .in_valid(req_i.valid), .in_ready(req_i.ready),
  .out_valid(rsp_o.valid), .out_ready(rsp_o.ready), .out_data(rsp_o.data)
);
